/* hdl/obpl_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// obpl_pkg
// Shared types, codes and constants of the one-button PIN lock pager.
// ---------------------------------------------------------------------------
package obpl_pkg;

  localparam int unsigned PIN_DIGITS = 4;
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned DIG_IDX_W  = $clog2(PIN_DIGITS);
  localparam int unsigned POS_W      = 3;
  localparam int unsigned PAGE_W     = 8;
  localparam int unsigned CNT_W      = 24;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned PIN_W      = PIN_DIGITS * DIG_W;

  localparam logic [DIG_W-1:0]  UNSET_DIGIT = 4'hF;
  localparam logic [DIG_W-1:0]  DIGIT_MAX   = 4'd9;
  localparam logic [POS_W-1:0]  LAST_POS    = POS_W'(PIN_DIGITS - 1);
  localparam logic [CNT_W-1:0]  COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [PAGE_W-1:0] FIRST_PAGE  = 8'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_PRESS = 3'd1,
    KIND_SHOW  = 3'd2,
    KIND_MODAL = 3'd3,
    KIND_POLL  = 3'd4,
    KIND_RESET = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIN_CODE     = 3'd0,
    CFG_LOCK_PAGE    = 3'd1,
    CFG_PAGE_COUNT   = 3'd2,
    CFG_IDLE_TIMEOUT = 3'd3,
    CFG_REFRESH_INT  = 3'd4,
    CFG_DIGIT_PAUSE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [PIN_W-1:0]  pin_code;
    logic [PAGE_W-1:0] lock_page;
    logic [PAGE_W-1:0] page_count;
    logic [CNT_W-1:0]  idle_timeout;
    logic [CNT_W-1:0]  refresh_interval;
    logic [CNT_W-1:0]  digit_pause;
  } cfg_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_now;
    logic              is_locked;
    logic              is_dark;
    logic              modal_on;
    logic              refresh_due;
    logic [POS_W-1:0]  digit_position;
    logic [PIN_W-1:0]  entered_digits;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

endpackage

/* hdl/obpl_cfg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// obpl_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module obpl_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [obpl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [obpl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output obpl_pkg::cfg_t                      cfg_o
);

  obpl_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (obpl_pkg::cfg_idx_e'(cfg_idx_i))
        obpl_pkg::CFG_PIN_CODE:     cfg_d.pin_code         = cfg_data_i[obpl_pkg::PIN_W-1:0];
        obpl_pkg::CFG_LOCK_PAGE:    cfg_d.lock_page        = cfg_data_i[obpl_pkg::PAGE_W-1:0];
        obpl_pkg::CFG_PAGE_COUNT:   cfg_d.page_count       = cfg_data_i[obpl_pkg::PAGE_W-1:0];
        obpl_pkg::CFG_IDLE_TIMEOUT: cfg_d.idle_timeout     = cfg_data_i[obpl_pkg::CNT_W-1:0];
        obpl_pkg::CFG_REFRESH_INT:  cfg_d.refresh_interval = cfg_data_i[obpl_pkg::CNT_W-1:0];
        obpl_pkg::CFG_DIGIT_PAUSE:  cfg_d.digit_pause      = cfg_data_i[obpl_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_code         <= '0;
      cfg_q.lock_page        <= '0;
      cfg_q.page_count       <= 8'd1;
      cfg_q.idle_timeout     <= 24'd30000;
      cfg_q.refresh_interval <= '0;
      cfg_q.digit_pause      <= 24'd2000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/obpl_engine.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// obpl_engine
// Pager state and its update for one staged item.
// ---------------------------------------------------------------------------
module obpl_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  obpl_pkg::kind_e                   kind_i,
  input  logic [obpl_pkg::PAGE_W-1:0]       page_request_i,
  input  obpl_pkg::cfg_t                    cfg_i,
  output obpl_pkg::res_t                    res_o
);

  logic [obpl_pkg::PAGE_W-1:0] page_q, page_d;
  logic                        locked_q, locked_d;
  logic                        dark_q, dark_d;
  logic                        modal_q, modal_d;
  logic                        rflag_q, rflag_d;
  logic [obpl_pkg::POS_W-1:0]  idx_q, idx_d;
  logic [obpl_pkg::DIG_W-1:0]  dig_q [obpl_pkg::PIN_DIGITS];
  logic [obpl_pkg::DIG_W-1:0]  dig_d [obpl_pkg::PIN_DIGITS];
  logic [obpl_pkg::CNT_W-1:0]  idle_q, idle_d;
  logic [obpl_pkg::CNT_W-1:0]  refr_q, refr_d;
  logic [obpl_pkg::CNT_W-1:0]  dcnt_q, dcnt_d;

  logic [obpl_pkg::CNT_W-1:0]  idle_inc, refr_inc, dcnt_inc;
  logic [obpl_pkg::DIG_W-1:0]  cur_dig;
  logic [obpl_pkg::PAGE_W-1:0] page_inc;
  logic [obpl_pkg::PIN_W-1:0]  entered_q, entered_d;
  logic                        pin_match;
  logic                        due;

  always_comb begin
    for (int i = 0; i < obpl_pkg::PIN_DIGITS; i++) begin
      entered_q[i*obpl_pkg::DIG_W +: obpl_pkg::DIG_W] = dig_q[i];
      entered_d[i*obpl_pkg::DIG_W +: obpl_pkg::DIG_W] = dig_d[i];
    end
  end

  assign idle_inc  = obpl_pkg::sat_inc(idle_q);
  assign refr_inc  = obpl_pkg::sat_inc(refr_q);
  assign dcnt_inc  = obpl_pkg::sat_inc(dcnt_q);
  assign cur_dig   = dig_q[idx_q[obpl_pkg::DIG_IDX_W-1:0]];
  assign pin_match = (entered_q == cfg_i.pin_code);
  assign page_inc  = dark_q ? page_q : page_q + 1'b1;

  always_comb begin
    page_d   = page_q;
    locked_d = locked_q;
    dark_d   = dark_q;
    modal_d  = modal_q;
    rflag_d  = rflag_q;
    idx_d    = idx_q;
    dig_d    = dig_q;
    idle_d   = idle_q;
    refr_d   = refr_q;
    dcnt_d   = dcnt_q;
    due      = 1'b0;
    if (step_i) begin
      unique case (kind_i)
        obpl_pkg::KIND_TICK: begin
          idle_d = idle_inc;
          refr_d = refr_inc;
          dcnt_d = dcnt_inc;
          if (idle_inc >= cfg_i.idle_timeout) begin
            locked_d = 1'b1;
            idx_d    = '0;
            for (int i = 0; i < obpl_pkg::PIN_DIGITS; i++) dig_d[i] = obpl_pkg::UNSET_DIGIT;
            if (!dark_q) begin
              dark_d  = 1'b1;
              modal_d = 1'b0;
            end
          end else begin
            if ((cfg_i.refresh_interval != '0) && (refr_inc >= cfg_i.refresh_interval)) begin
              rflag_d = 1'b1;
              refr_d  = '0;
            end
            if (locked_q && (dcnt_inc >= cfg_i.digit_pause) &&
                (dig_q[0] != obpl_pkg::UNSET_DIGIT)) begin
              rflag_d = 1'b1;
              if (pin_match) begin
                locked_d = 1'b0;
                page_d   = obpl_pkg::FIRST_PAGE;
                modal_d  = 1'b0;
                dark_d   = 1'b0;
                idle_d   = '0;
              end else if ((cur_dig == obpl_pkg::UNSET_DIGIT) ||
                           (idx_q >= obpl_pkg::LAST_POS)) begin
                // pause on an unset digit, or at the last digit: start over
                locked_d = 1'b1;
                idx_d    = '0;
                for (int i = 0; i < obpl_pkg::PIN_DIGITS; i++) begin
                  dig_d[i] = obpl_pkg::UNSET_DIGIT;
                end
                if (cur_dig != obpl_pkg::UNSET_DIGIT) dcnt_d = '0;
              end else begin
                idx_d  = idx_q + 1'b1;
                dcnt_d = '0;
              end
            end
          end
        end
        obpl_pkg::KIND_PRESS: begin
          if (locked_q) begin
            page_d = cfg_i.lock_page;
            if (!dark_q) begin
              dig_d[idx_q[obpl_pkg::DIG_IDX_W-1:0]] =
                (cur_dig >= obpl_pkg::DIGIT_MAX) ? '0 : cur_dig + 1'b1;
            end
            dcnt_d = '0;
          end else begin
            page_d = ((page_inc == '0) || (page_inc > cfg_i.page_count)) ?
                     obpl_pkg::FIRST_PAGE : page_inc;
          end
          modal_d = 1'b0;
          rflag_d = 1'b1;
          dark_d  = 1'b0;
          idle_d  = '0;
        end
        obpl_pkg::KIND_SHOW: begin
          page_d  = page_request_i;
          rflag_d = 1'b1;
          modal_d = 1'b0;
          dark_d  = 1'b0;
          idle_d  = '0;
        end
        obpl_pkg::KIND_MODAL: begin
          modal_d = 1'b1;
          dark_d  = 1'b0;
          idle_d  = '0;
        end
        obpl_pkg::KIND_POLL: begin
          if (!modal_q) begin
            due     = rflag_q;
            rflag_d = 1'b0;
          end
        end
        obpl_pkg::KIND_RESET: begin
          page_d   = '0;
          dark_d   = 1'b1;
          modal_d  = 1'b0;
          locked_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q   <= '0;
      locked_q <= 1'b1;
      dark_q   <= 1'b1;
      modal_q  <= 1'b0;
      rflag_q  <= 1'b0;
      idx_q    <= '0;
      for (int i = 0; i < obpl_pkg::PIN_DIGITS; i++) dig_q[i] <= obpl_pkg::UNSET_DIGIT;
      idle_q   <= '0;
      refr_q   <= '0;
      dcnt_q   <= '0;
    end else begin
      page_q   <= page_d;
      locked_q <= locked_d;
      dark_q   <= dark_d;
      modal_q  <= modal_d;
      rflag_q  <= rflag_d;
      idx_q    <= idx_d;
      dig_q    <= dig_d;
      idle_q   <= idle_d;
      refr_q   <= refr_d;
      dcnt_q   <= dcnt_d;
    end
  end

  always_comb begin
    res_o.page_now       = page_d;
    res_o.is_locked      = locked_d;
    res_o.is_dark        = dark_d;
    res_o.modal_on       = modal_d;
    res_o.refresh_due    = due;
    res_o.digit_position = idx_d;
    res_o.entered_digits = entered_d;
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= obpl_pkg::LAST_POS)
    else $error("digit index out of range");

  a_press_wakes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (kind_i == obpl_pkg::KIND_PRESS) |=> !dark_q && rflag_q && !modal_q)
    else $error("press did not wake the display");

  a_soft_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (kind_i == obpl_pkg::KIND_RESET) |=> locked_q && dark_q && (page_q == '0))
    else $error("soft reset state wrong");

  a_poll_modal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (kind_i == obpl_pkg::KIND_POLL) && modal_q |=> rflag_q == $past(rflag_q))
    else $error("poll under modal changed the refresh flag");

  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(idle_q) && $stable(idx_q) && $stable(locked_q))
    else $error("state moved without an item");

endmodule

/* hdl/one_button_pin_lock_pager_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// one_button_pin_lock_pager_core
// One-button page selector with a four-digit PIN lock, idle lock-out and
// refresh bookkeeping. One result item for every input item.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o  | kind_i, page_request_i
//  out     | output    | out_valid_o / out_ready_i| page_now_o .. entered_digits_o
//  cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
//  One item per cycle sustained while out_ready_i is high; a result is valid
//  after the item passes the input register, then the state update into the result register.
//  Reset loads valid flags, engine state and register defaults; no clearing pass.
//  An output stall holds the staged item; input stays ready while the staged
//  item can move into a free or draining result register.
// ---------------------------------------------------------------------------
module one_button_pin_lock_pager_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [obpl_pkg::KIND_W-1:0]       kind_i,
  input  logic [obpl_pkg::PAGE_W-1:0]       page_request_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [obpl_pkg::PAGE_W-1:0]       page_now_o,
  output logic                              is_locked_o,
  output logic                              is_dark_o,
  output logic                              modal_on_o,
  output logic                              refresh_due_o,
  output logic [obpl_pkg::POS_W-1:0]        digit_position_o,
  output logic [obpl_pkg::PIN_W-1:0]        entered_digits_o,
  input  logic                              cfg_we_i,
  input  logic [obpl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [obpl_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  obpl_pkg::cfg_t              cfg;
  obpl_pkg::res_t              res_d, res_q;
  logic                        stg_valid_q, stg_valid_d;
  logic [obpl_pkg::KIND_W-1:0] stg_kind_q;
  logic [obpl_pkg::PAGE_W-1:0] stg_req_q;
  logic                        out_valid_q, out_valid_d;
  logic                        advance;
  logic                        in_fire;

  obpl_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance    = stg_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !stg_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  obpl_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .kind_i         (obpl_pkg::kind_e'(stg_kind_q)),
    .page_request_i (stg_req_q),
    .cfg_i          (cfg),
    .res_o          (res_d)
  );

  always_comb begin
    stg_valid_d = in_fire ? 1'b1 : (advance ? 1'b0 : stg_valid_q);
    out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_kind_q <= kind_i;
      stg_req_q  <= page_request_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign page_now_o       = res_q.page_now;
  assign is_locked_o      = res_q.is_locked;
  assign is_dark_o        = res_q.is_dark;
  assign modal_on_o       = res_q.modal_on;
  assign refresh_due_o    = res_q.refresh_due;
  assign digit_position_o = res_q.digit_position;
  assign entered_digits_o = res_q.entered_digits;

endmodule
